### hdl/cgi_pkg.sv
// ----------------------------------------------------------------------------
// cgi_pkg: shared types and constants of the color gradient interpolator
// Holds the key record, the pipeline mode codes and the fixed field widths.
// ----------------------------------------------------------------------------
package cgi_pkg;

  // Age fraction is unsigned Q1.16, so it spans 17 bits.
  localparam int unsigned T_W     = 17;
  localparam int unsigned RGBA_W  = 32;
  localparam int unsigned CH_NUM  = 4;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned KCNT_W  = 3;
  // A channel numerator is at most 255 times the segment width.
  localparam int unsigned NUM_W   = CH_W + T_W;
  localparam int unsigned KEY_W   = T_W + RGBA_W;
  localparam int unsigned APB_AW  = 6;
  localparam int unsigned APB_DW  = 64;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_KEY_COUNT = 3'd0;

  // One gradient key: time and packed RGBA color.
  typedef struct packed {
    logic [T_W-1:0]    t;
    logic [RGBA_W-1:0] rgba;
  } key_t;

  // What an item carries down the pipeline.
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0, // gradient disabled, no color
    MODE_COLOR = 2'd1, // a key color passes through unchanged
    MODE_TIME  = 2'd2, // age fraction still to be mapped
    MODE_BLEND = 2'd3  // channels to be interpolated
  } mode_e;

endpackage

### hdl/cgi_if.sv
// ----------------------------------------------------------------------------
// cgi_if: item channels of the color gradient interpolator
// Valid/ready channels for particle lifetimes in and colors out.
// ----------------------------------------------------------------------------
interface cgi_in_if #(
  parameter int unsigned LIFE_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic [LIFE_BITS-1:0] remaining_life;
  logic [LIFE_BITS-1:0] full_life;

  modport source (output valid, output remaining_life, output full_life, input ready);
  modport sink   (input valid, input remaining_life, input full_life, output ready);
endinterface

interface cgi_out_if;
  logic       valid;
  logic       ready;
  logic       color_valid;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output color_valid, output red, output green,
                  output blue, output alpha, input ready);
  modport sink   (input valid, input color_valid, input red, input green,
                  input blue, input alpha, output ready);
endinterface

### hdl/cgi_regs.sv
// ----------------------------------------------------------------------------
// cgi_regs: configuration register file
// APB-style access to the key count and the gradient keys.
// ----------------------------------------------------------------------------
module cgi_regs import cgi_pkg::*; #(
  parameter int unsigned MAX_KEYS = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [KCNT_W-1:0] key_cnt_o,
  output key_t              keys_o [MAX_KEYS]
);

  logic [KCNT_W-1:0] cnt_q;
  key_t              key_q [MAX_KEYS];
  logic [2:0]        idx;
  logic              wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; registers are eight bytes apart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < MAX_KEYS; i++) begin
        key_q[i] <= '0;
      end
    end else if (wr) begin
      if (idx == REG_KEY_COUNT) begin
        cnt_q <= pwdata[KCNT_W-1:0];
      end
      for (int i = 0; i < MAX_KEYS; i++) begin
        if (idx == 3'(i + 1)) begin
          key_q[i] <= pwdata[KEY_W-1:0];
        end
      end
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (idx == REG_KEY_COUNT) begin
      prdata = APB_DW'(cnt_q);
    end
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (idx == 3'(i + 1)) begin
        prdata = APB_DW'(key_q[i]);
      end
    end
  end

  assign key_cnt_o = cnt_q;
  assign keys_o    = key_q;

endmodule

### hdl/cgi_age_div.sv
// ----------------------------------------------------------------------------
// cgi_age_div: age fraction divider
// Classifies an item and forms t = (full - remaining) * 2^16 / full with
// one restoring quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module cgi_age_div import cgi_pkg::*; #(
  parameter int unsigned LIFE_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [LIFE_BITS-1:0] remaining_life_i,
  input  logic [LIFE_BITS-1:0] full_life_i,
  input  logic [KCNT_W-1:0]    key_cnt_i,
  output logic                 vld_o,
  output mode_e                mode_o,
  output logic [T_W-1:0]       t_o
);

  localparam int unsigned RW = LIFE_BITS + 1;

  logic                 vld_q  [T_W+1];
  mode_e                mode_q [T_W+1];
  logic [RW-1:0]        r_q    [T_W+1];
  logic [LIFE_BITS-1:0] dv_q   [T_W+1];
  logic [T_W-1:0]       q_q    [T_W+1];

  logic [RW-1:0] diff;
  mode_e         mode_d;

  // Entry: decide which items need the divide at all.
  always_comb begin
    diff = {1'b0, full_life_i} - {1'b0, remaining_life_i};
    if (key_cnt_i == '0) begin
      mode_d = MODE_OFF;
    end else if (key_cnt_i == KCNT_W'(1) || full_life_i == '0 ||
                 remaining_life_i >= full_life_i) begin
      mode_d = MODE_COLOR;
    end else begin
      mode_d = MODE_TIME;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q[0] <= mode_d;
      r_q[0]    <= diff;
      dv_q[0]   <= full_life_i;
      q_q[0]    <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < T_W; k++) begin : g_step
    logic [RW-1:0] r_in;
    logic          ge;

    always_comb begin
      if (k == 0) begin
        r_in = r_q[k];
      end else begin
        r_in = {r_q[k][RW-2:0], 1'b0};
      end
      ge = r_in >= {1'b0, dv_q[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mode_q[k+1] <= mode_q[k];
        r_q[k+1]    <= ge ? r_in - {1'b0, dv_q[k]} : r_in;
        dv_q[k+1]   <= dv_q[k];
        q_q[k+1]    <= {q_q[k][T_W-2:0], ge};
      end
    end
  end

  assign vld_o  = vld_q[T_W];
  assign mode_o = mode_q[T_W];
  assign t_o    = q_q[T_W];

endmodule

### hdl/cgi_seg_mul.sv
// ----------------------------------------------------------------------------
// cgi_seg_mul: segment select and blend numerators
// Picks the key pair around t, then forms per channel
// c_lo * (w - d) + c_hi * d in a second stage.
// ----------------------------------------------------------------------------
module cgi_seg_mul import cgi_pkg::*; #(
  parameter int unsigned MAX_KEYS = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [KCNT_W-1:0] key_cnt_i,
  input  key_t              keys_i [MAX_KEYS],
  input  logic              vld_i,
  input  mode_e             mode_i,
  input  logic [T_W-1:0]    t_i,
  output logic              vld_o,
  output mode_e             mode_o,
  output logic [RGBA_W-1:0] rgba_o,
  output logic [NUM_W-1:0]  num_o [CH_NUM],
  output logic [T_W-1:0]    w_o
);

  logic [KCNT_W-1:0] last;
  key_t              key_last;
  key_t              seg_lo;
  key_t              seg_hi;
  logic              found;
  mode_e             mode_d;
  logic [RGBA_W-1:0] lo_d;

  logic              a_vld_q;
  mode_e             a_mode_q;
  logic [RGBA_W-1:0] a_lo_q;
  logic [RGBA_W-1:0] a_hi_q;
  logic [T_W-1:0]    a_d_q;
  logic [T_W-1:0]    a_w_q;

  logic              b_vld_q;
  mode_e             b_mode_q;
  logic [RGBA_W-1:0] b_rgba_q;
  logic [NUM_W-1:0]  b_num_q [CH_NUM];
  logic [T_W-1:0]    b_w_q;

  // Last key in use and the first segment that brackets t.
  always_comb begin
    last     = key_cnt_i - KCNT_W'(1);
    key_last = keys_i[0];
    seg_lo   = keys_i[0];
    seg_hi   = keys_i[0];
    found    = 1'b0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (last == KCNT_W'(i)) begin
        key_last = keys_i[i];
      end
    end
    for (int i = MAX_KEYS - 2; i >= 0; i--) begin
      if (KCNT_W'(i) < last && t_i >= keys_i[i].t && t_i <= keys_i[i+1].t) begin
        found  = 1'b1;
        seg_lo = keys_i[i];
        seg_hi = keys_i[i+1];
      end
    end
  end

  // Clamp at either end, a zero-width segment keeps its lower key.
  always_comb begin
    mode_d = MODE_COLOR;
    lo_d   = keys_i[0].rgba;
    case (mode_i)
      MODE_OFF: begin
        mode_d = MODE_OFF;
        lo_d   = '0;
      end
      MODE_TIME: begin
        if (t_i <= keys_i[0].t) begin
          lo_d = keys_i[0].rgba;
        end else if (t_i >= key_last.t) begin
          lo_d = key_last.rgba;
        end else if (found) begin
          lo_d = seg_lo.rgba;
          if (seg_hi.t != seg_lo.t) begin
            mode_d = MODE_BLEND;
          end
        end else begin
          lo_d = key_last.rgba;
        end
      end
      default: begin
        mode_d = MODE_COLOR;
        lo_d   = keys_i[0].rgba;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mode_q <= mode_d;
      a_lo_q   <= lo_d;
      a_hi_q   <= seg_hi.rgba;
      a_d_q    <= t_i - seg_lo.t;
      a_w_q    <= seg_hi.t - seg_lo.t;
    end
  end

  // Weighted channel sums; a blended color is rebuilt bit by bit downstream.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_mode_q <= a_mode_q;
      b_w_q    <= a_w_q;
      b_rgba_q <= (a_mode_q == MODE_BLEND) ? '0 : a_lo_q;
      for (int c = 0; c < CH_NUM; c++) begin
        b_num_q[c] <= NUM_W'(a_lo_q[c*CH_W +: CH_W] * (a_w_q - a_d_q))
                    + NUM_W'(a_hi_q[c*CH_W +: CH_W] * a_d_q);
      end
    end
  end

  assign vld_o  = b_vld_q;
  assign mode_o = b_mode_q;
  assign rgba_o = b_rgba_q;
  assign num_o  = b_num_q;
  assign w_o    = b_w_q;

endmodule

### hdl/cgi_blend_div.sv
// ----------------------------------------------------------------------------
// cgi_blend_div: channel divider
// Divides each channel sum by the segment width, one quotient bit per stage,
// and holds the finished color in its last stage.
// ----------------------------------------------------------------------------
module cgi_blend_div import cgi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  mode_e             mode_i,
  input  logic [RGBA_W-1:0] rgba_i,
  input  logic [NUM_W-1:0]  num_i [CH_NUM],
  input  logic [T_W-1:0]    w_i,
  output logic              vld_o,
  output logic              color_valid_o,
  output logic [RGBA_W-1:0] rgba_o
);

  logic              vld_q  [CH_W+1];
  mode_e             mode_q [CH_W+1];
  logic [RGBA_W-1:0] rgba_q [CH_W+1];
  logic [NUM_W-1:0]  r_q    [CH_W+1][CH_NUM];
  logic [T_W-1:0]    w_q    [CH_W+1];

  assign vld_q[0]  = vld_i;
  assign mode_q[0] = mode_i;
  assign rgba_q[0] = rgba_i;
  assign r_q[0]    = num_i;
  assign w_q[0]    = w_i;

  for (genvar k = 0; k < CH_W; k++) begin : g_step
    localparam int unsigned BIT = CH_W - 1 - k;
    logic [NUM_W-1:0]  dv;
    logic [NUM_W-1:0]  r_d    [CH_NUM];
    logic [RGBA_W-1:0] rgba_d;

    // Trial subtract of the shifted width on every channel.
    always_comb begin
      dv     = NUM_W'(w_q[k]) << BIT;
      rgba_d = rgba_q[k];
      for (int c = 0; c < CH_NUM; c++) begin
        r_d[c] = r_q[k][c];
        if (r_q[k][c] >= dv) begin
          r_d[c] = r_q[k][c] - dv;
          if (mode_q[k] == MODE_BLEND) begin
            rgba_d[c*CH_W + BIT] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mode_q[k+1] <= mode_q[k];
        rgba_q[k+1] <= rgba_d;
        r_q[k+1]    <= r_d;
        w_q[k+1]    <= w_q[k];
      end
    end
  end

  assign vld_o         = vld_q[CH_W];
  assign color_valid_o = mode_q[CH_W] != MODE_OFF;
  assign rgba_o        = rgba_q[CH_W];

endmodule

### hdl/color_gradient_interpolator_top.sv
// Throughput: one item per cycle unless the output stalls; the 17-step age
// divider, the segment and multiply stages and the 8-step channel divider are
// all fully pipelined.
// The whole pipeline holds while a finished color waits for the sink.
// Reset clears all valid bits, the key count and the keys to zero.
// ----------------------------------------------------------------------------
// color_gradient_interpolator_top: particle color over lifetime
// Maps a particle's age fraction through a ramp of RGBA keys.
// ----------------------------------------------------------------------------
module color_gradient_interpolator_top import cgi_pkg::*; #(
  parameter int unsigned MAX_KEYS  = 7,
  parameter int unsigned LIFE_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cgi_in_if.sink            in_i,
  cgi_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic              en;
  logic [KCNT_W-1:0] key_cnt;
  logic [KCNT_W-1:0] n_keys;
  key_t              keys [MAX_KEYS];

  logic              age_vld;
  mode_e             age_mode;
  logic [T_W-1:0]    age_t;

  logic              seg_vld;
  mode_e             seg_mode;
  logic [RGBA_W-1:0] seg_rgba;
  logic [NUM_W-1:0]  seg_num [CH_NUM];
  logic [T_W-1:0]    seg_w;

  logic              fin_vld;
  logic              fin_cvalid;
  logic [RGBA_W-1:0] fin_rgba;

  // The pipeline moves unless a finished item is stuck at the output.
  assign en         = !fin_vld || out_o.ready;
  assign in_i.ready = en;

  // Counts beyond the key storage use all stored keys.
  assign n_keys = (key_cnt > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : key_cnt;

  cgi_regs #(.MAX_KEYS(MAX_KEYS)) u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .key_cnt_o (key_cnt),
    .keys_o    (keys)
  );

  cgi_age_div #(.LIFE_BITS(LIFE_BITS)) u_age_div (
    .clk_i, .rst_ni,
    .en_i             (en),
    .vld_i            (in_i.valid),
    .remaining_life_i (in_i.remaining_life),
    .full_life_i      (in_i.full_life),
    .key_cnt_i        (n_keys),
    .vld_o            (age_vld),
    .mode_o           (age_mode),
    .t_o              (age_t)
  );

  cgi_seg_mul #(.MAX_KEYS(MAX_KEYS)) u_seg_mul (
    .clk_i, .rst_ni,
    .en_i      (en),
    .key_cnt_i (n_keys),
    .keys_i    (keys),
    .vld_i     (age_vld),
    .mode_i    (age_mode),
    .t_i       (age_t),
    .vld_o     (seg_vld),
    .mode_o    (seg_mode),
    .rgba_o    (seg_rgba),
    .num_o     (seg_num),
    .w_o       (seg_w)
  );

  cgi_blend_div u_blend_div (
    .clk_i, .rst_ni,
    .en_i          (en),
    .vld_i         (seg_vld),
    .mode_i        (seg_mode),
    .rgba_i        (seg_rgba),
    .num_i         (seg_num),
    .w_i           (seg_w),
    .vld_o         (fin_vld),
    .color_valid_o (fin_cvalid),
    .rgba_o        (fin_rgba)
  );

  assign out_o.valid       = fin_vld;
  assign out_o.color_valid = fin_cvalid;
  assign out_o.red         = fin_rgba[31:24];
  assign out_o.green       = fin_rgba[23:16];
  assign out_o.blue        = fin_rgba[15:8];
  assign out_o.alpha       = fin_rgba[7:0];

endmodule

### hdl/cgi_checker.sv
// ----------------------------------------------------------------------------
// cgi_checker: port-level checks of the color gradient interpolator
// Watches the item channels and the configuration port over time.
// ----------------------------------------------------------------------------
module cgi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_color_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       pready
);

  // A stalled item keeps its color.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_color_valid) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue) &&
      $stable(out_alpha))
    else $error("stalled output item changed");

  // Input is held off exactly while the output is stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // A disabled gradient reports a zero color.
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_color_valid |-> out_red == 8'd0 && out_green == 8'd0 &&
      out_blue == 8'd0 && out_alpha == 8'd0)
    else $error("disabled item carries a color");

  // The register port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind color_gradient_interpolator_top cgi_checker u_cgi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_color_valid (out_o.color_valid),
  .out_red         (out_o.red),
  .out_green       (out_o.green),
  .out_blue        (out_o.blue),
  .out_alpha       (out_o.alpha),
  .pready          (pready)
);
